@@ src/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, held off while in reset
`define ASSERT_CLK(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error(msg);

// same check, also active during reset
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ src/rle_pkg.sv @@
package rle_pkg;

  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;

  // header of a segment that holds one lone byte
  localparam logic [BYTE_W-1:0] HDR_SINGLE = 8'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        group_last;
    logic        stream_end;
  } out_item_t;

endpackage

@@ src/rle_run_literal_encoder_unit.sv @@
// channel | direction | payload             | handshake
// in_     | input     | rle_pkg::in_item_t  | in_valid / in_stall
// out_    | output    | rle_pkg::out_item_t | out_valid / out_stall
//
// an input transaction that closes no segment is taken while the unit stays idle
// a closing transaction drains the header, then the run byte (for a run) or each
// literal byte, then a header and the byte when a lone final byte follows; the
// drain moves one byte per cycle through the single read port of the segment store
// out_stall pauses the drain while a packed word waits; in_stall is high
// for the whole drain
// rst_n is synchronous; the segment store is not cleared (no clearing pass)
`include "assert_macros.svh"

module rle_run_literal_encoder_unit #(
  parameter int MAX_SEGMENT = 127,
  parameter int WORD_BYTES  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rle_pkg::out_item_t out_data
);
  import rle_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENT);
  localparam int CW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_SEGMENT);
  localparam logic [CW-1:0]    LAST_SLOT = CW'(WORD_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_DATA,
    S_TAIL1,
    S_TAILB
  } state_t;

  // segment store: one write port, one registered read port
  logic [BYTE_W-1:0] mem [MAX_SEGMENT];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] rd_data_r;

  // open segment
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              kind_r, kind_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;

  // segment being drained
  logic [LEN_W-1:0]  dr_len_r, dr_len_nxt;
  logic              dr_run_r, dr_run_nxt;
  logic              dr_tail_r, dr_tail_nxt;
  logic              dr_pend_r, dr_pend_nxt;
  logic              dr_fin_r, dr_fin_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;

  // word packer and output register
  logic [63:0]       pack_r, pack_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              same;
  logic              full;
  logic              push_ok;
  logic              push;
  logic              push_last;
  logic [BYTE_W-1:0] push_byte;
  logic              last_data;
  logic [63:0]       word;
  logic              flush;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign same      = (prev_r == in_data.data_byte);
  assign full      = (len_r >= MAX_LEN);
  assign push_ok   = !out_valid_r || !out_stall;
  assign last_data = dr_run_r || ((LEN_W'(idx_r) + LEN_W'(1)) == dr_len_r);

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    kind_nxt    = kind_r;
    prev_nxt    = prev_r;
    dr_len_nxt  = dr_len_r;
    dr_run_nxt  = dr_run_r;
    dr_tail_nxt = dr_tail_r;
    dr_pend_nxt = dr_pend_r;
    dr_fin_nxt  = dr_fin_r;
    byte_nxt    = byte_r;
    idx_nxt     = idx_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = in_data.data_byte;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    push        = 1'b0;
    push_last   = 1'b0;
    push_byte   = '0;

    if (accept) begin
      byte_nxt    = in_data.data_byte;
      dr_fin_nxt  = in_data.final_byte;
      dr_tail_nxt = 1'b0;
      dr_pend_nxt = 1'b0;
      idx_nxt     = '0;
      if (len_r == '0) begin
        if (in_data.final_byte) begin
          // lone byte at stream end
          dr_tail_nxt = 1'b1;
          state_nxt   = S_TAIL1;
        end else begin
          mem_we    = 1'b1;
          len_nxt   = LEN_W'(1);
          prev_nxt  = in_data.data_byte;
        end
      end else if (len_r == LEN_W'(1)) begin
        // second byte fixes the segment kind
        kind_nxt  = same;
        mem_we    = 1'b1;
        mem_waddr = AW'(1);
        len_nxt   = LEN_W'(2);
        prev_nxt  = in_data.data_byte;
        if (in_data.final_byte) begin
          dr_len_nxt = LEN_W'(2);
          dr_run_nxt = same;
          mem_re     = 1'b1;
          state_nxt  = S_HDR;
        end
      end else if ((same != kind_r) || full) begin
        // close the open segment; this byte opens the next one, or goes out alone if final
        dr_len_nxt = len_r;
        dr_run_nxt = kind_r;
        mem_re     = 1'b1;
        state_nxt  = S_HDR;
        if (in_data.final_byte) begin
          dr_tail_nxt = 1'b1;
        end else begin
          // store[0] is still needed by the drain, write it at drain end
          dr_pend_nxt = 1'b1;
          len_nxt     = LEN_W'(1);
          prev_nxt    = in_data.data_byte;
        end
      end else begin
        mem_we    = 1'b1;
        mem_waddr = len_r[AW-1:0];
        len_nxt   = len_r + LEN_W'(1);
        prev_nxt  = in_data.data_byte;
        if (in_data.final_byte) begin
          dr_len_nxt = len_r + LEN_W'(1);
          dr_run_nxt = kind_r;
          mem_re     = 1'b1;
          state_nxt  = S_HDR;
        end
      end
      if (in_data.final_byte) begin
        len_nxt  = '0;
        kind_nxt = 1'b0;
        prev_nxt = '0;
      end
    end else if (push_ok) begin
      unique case (state_r)
        S_IDLE: begin
        end
        S_HDR: begin
          push      = 1'b1;
          push_byte = {dr_run_r, dr_len_r};
          state_nxt = S_DATA;
        end
        S_DATA: begin
          push      = 1'b1;
          push_byte = rd_data_r;
          if (last_data) begin
            if (dr_tail_r) begin
              state_nxt = S_TAIL1;
            end else begin
              push_last = 1'b1;
              state_nxt = S_IDLE;
              if (dr_pend_r) begin
                mem_we    = 1'b1;
                mem_wdata = byte_r;
              end
            end
          end else begin
            idx_nxt   = idx_r + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_r + AW'(1);
          end
        end
        S_TAIL1: begin
          push      = 1'b1;
          push_byte = HDR_SINGLE;
          state_nxt = S_TAILB;
        end
        S_TAILB: begin
          push      = 1'b1;
          push_byte = byte_r;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // byte packer
  assign word  = pack_r | (64'(push_byte) << {cnt_r, 3'b000});
  assign flush = push && (push_last || (cnt_r == LAST_SLOT));

  always_comb begin
    pack_nxt      = pack_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (push) begin
      if (flush) begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.out_word   = word;
        out_data_nxt.byte_count = 4'(cnt_r) + 4'd1;
        out_data_nxt.group_last = push_last;
        out_data_nxt.stream_end = push_last && dr_fin_r;
        pack_nxt                = '0;
        cnt_nxt                 = '0;
      end else begin
        pack_nxt = word;
        cnt_nxt  = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      kind_r      <= 1'b0;
      prev_r      <= '0;
      dr_tail_r   <= 1'b0;
      dr_pend_r   <= 1'b0;
      dr_fin_r    <= 1'b0;
      pack_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      kind_r      <= kind_nxt;
      prev_r      <= prev_nxt;
      dr_tail_r   <= dr_tail_nxt;
      dr_pend_r   <= dr_pend_nxt;
      dr_fin_r    <= dr_fin_nxt;
      pack_r      <= pack_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dr_len_r   <= dr_len_nxt;
    dr_run_r   <= dr_run_nxt;
    byte_r     <= byte_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_len_bound, clk, rst_n, len_r <= MAX_LEN,
    "open segment longer than the store")
  `ASSERT_CLK(a_count_range, clk, rst_n,
    out_valid_r |-> (out_data_r.byte_count != 4'd0) &&
      (out_data_r.byte_count <= 4'(WORD_BYTES)),
    "byte count out of range")
  `ASSERT_CLK(a_end_is_last, clk, rst_n,
    out_valid_r && out_data_r.stream_end |-> out_data_r.group_last,
    "stream end without group end")
  `ASSERT_CLK(a_fin_clears, clk, rst_n,
    in_valid && !in_stall && in_data.final_byte |=>
      (len_r == '0) && (prev_r == '0) && !kind_r,
    "segment state not cleared after final byte")

endmodule

@@ tb/rle_run_literal_encoder_unit_tb.sv @@
`timescale 1ns / 1ps

module rle_run_literal_encoder_unit_tb;

  // segment limits of the encoder, as built with default parameters
  localparam int MAX_SEG = 127;
  localparam int WORD_B = 8;
  localparam logic [7:0] RUN_FLAG = 8'd128;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // drain time after the last expected word (longest close plus margin)
  localparam int TAIL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rle_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rle_pkg::out_item_t out_data;

  rle_run_literal_encoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // raw byte stream waiting to be sent, and encoded words still owed
  rle_pkg::in_item_t raw_bytes_q[$];
  rle_pkg::out_item_t encoded_words_q[$];
  logic [7:0] last_queued = 8'd0;

  // shadow of the encoder state
  logic [7:0] seg_bytes [MAX_SEG];
  logic [7:0] seg_len = 8'd0;
  bit seg_run = 1'b0;
  logic [7:0] prev_byte = 8'd0;
  logic [7:0] enc_bytes[$];

  int errors = 0;
  int n_in = 0;
  int n_streams = 0;
  int n_words = 0;
  int idle_cycles = 0;
  bit in_fire = 1'b0;
  rle_pkg::out_item_t want_word;

  // ---------------------------------------------------------------------------
  // encoder prediction
  // ---------------------------------------------------------------------------

  // write out the open segment: header, then the run byte or every literal byte
  function automatic void flush_segment();
    if (seg_len == 0) return;
    if (seg_run) begin
      enc_bytes.push_back(RUN_FLAG | seg_len);
      enc_bytes.push_back(seg_bytes[0]);
    end else begin
      enc_bytes.push_back(seg_len);
      for (int j = 0; j < seg_len; j++) enc_bytes.push_back(seg_bytes[j]);
    end
    seg_len = 8'd0;
  endfunction

  // open a segment with this byte; a final byte goes out alone at once
  function automatic void start_segment(input logic [7:0] b, input bit fin);
    if (fin) begin
      enc_bytes.push_back(rle_pkg::HDR_SINGLE);
      enc_bytes.push_back(b);
      seg_len = 8'd0;
    end else begin
      seg_bytes[0] = b;
      seg_len = 8'd1;
      prev_byte = b;
    end
  endfunction

  // one accepted byte -> zero or more packed words on the expected queue
  function automatic void encode_byte(input rle_pkg::in_item_t it);
    bit same;
    bit closed;
    logic [3:0] n;
    rle_pkg::out_item_t w;
    enc_bytes.delete();
    closed = 1'b0;
    if (seg_len == 0) begin
      start_segment(it.data_byte, it.final_byte);
    end else begin
      same = (prev_byte == it.data_byte);
      if (seg_len == 1) begin
        // second byte fixes run or literal
        seg_run = same;
      end else if (same != seg_run || seg_len >= MAX_SEG) begin
        // kind change or full segment
        flush_segment();
        closed = 1'b1;
      end
      if (closed) begin
        start_segment(it.data_byte, it.final_byte);
      end else begin
        if (seg_len < MAX_SEG) begin
          seg_bytes[seg_len[6:0]] = it.data_byte;
          seg_len++;
        end
        prev_byte = it.data_byte;
        if (it.final_byte) flush_segment();
      end
    end
    // end of stream puts the encoder back to idle
    if (it.final_byte) begin
      seg_len = 8'd0;
      seg_run = 1'b0;
      prev_byte = 8'd0;
    end
    // pack up to eight bytes per word, first byte lowest
    while (enc_bytes.size() > 0) begin
      w = '0;
      n = (enc_bytes.size() > WORD_B) ? 4'(WORD_B) : 4'(enc_bytes.size());
      for (int j = 0; j < n; j++) w.out_word[8*j +: 8] = enc_bytes.pop_front();
      w.byte_count = n;
      w.group_last = (enc_bytes.size() == 0);
      w.stream_end = w.group_last && it.final_byte;
      encoded_words_q.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] b, input bit fin);
    rle_pkg::in_item_t it;
    it.data_byte = b;
    it.final_byte = fin;
    raw_bytes_q.push_back(it);
    last_queued = b;
  endfunction

  function automatic void queue_run(input logic [7:0] b, input int len, input bit fin);
    for (int i = 0; i < len; i++) queue_byte(b, fin && (i == len - 1));
  endfunction

  // adjacent bytes always differ so the chunk stays a literal
  function automatic void queue_literal(input int len, input bit fin);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      while (b == last_queued) b = 8'($urandom);
      queue_byte(b, fin && (i == len - 1));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (raw_bytes_q.size() > 0) begin
        in_data <= raw_bytes_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // about half the bursts run straight into the next one
          gap_left <= ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stall pattern: stall modes picked at random, one after another
  // ---------------------------------------------------------------------------

  int stall_mode = 0;
  int stall_phase = 0;

  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(8, 60);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) != 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_phase % 7) < 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted input, compare on accepted output
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      encode_byte(in_data);
      n_in++;
      if (in_data.final_byte) n_streams++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (encoded_words_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none,", $time);
        $display("  actual word=%h cnt=%0d last=%0b end=%0b",
                 out_data.out_word, out_data.byte_count, out_data.group_last,
                 out_data.stream_end);
      end else begin
        want_word = encoded_words_q.pop_front();
        n_words++;
        if (out_data.out_word !== want_word.out_word ||
            out_data.byte_count !== want_word.byte_count ||
            out_data.group_last !== want_word.group_last ||
            out_data.stream_end !== want_word.stream_end) begin
          errors++;
          $display("%0t: mismatch, expected word=%h cnt=%0d last=%0b end=%0b,",
                   $time, want_word.out_word, want_word.byte_count,
                   want_word.group_last, want_word.stream_end);
          $display("  actual word=%h cnt=%0d last=%0b end=%0b",
                   out_data.out_word, out_data.byte_count,
                   out_data.group_last, out_data.stream_end);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d input transactions sent, %0d words still expected",
               $time, n_in, encoded_words_q.size());
      $display("rle_run_literal_encoder_unit_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of test
  // ---------------------------------------------------------------------------

  initial begin
    int kind;
    int chunks;
    int len;
    logic [7:0] rb;
    bit last;

    // lone final bytes at both extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    // short run
    queue_run(8'hff, 3, 1'b1);
    // literal keeps the first byte of the run that follows
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_run(8'h03, 3, 1'b1);
    // run closed by a literal
    queue_run(8'haa, 2, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h5a, 1'b1);
    // final byte closes a literal by kind change, then goes out alone
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h20, 1'b1);
    // two-byte literal stream
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7f, 1'b1);

    // full run whose final byte arrives as the segment is full
    rb = 8'($urandom);
    queue_run(rb, MAX_SEG + 1, 1'b1);
    // full literal, then a run across the boundary
    queue_literal(MAX_SEG + 2, 1'b0);
    rb = 8'($urandom);
    queue_run(rb, 4, 1'b1);

    // random streams: mostly chunks of runs and literals, some noise
    while (raw_bytes_q.size() < 300) begin
      kind = $urandom_range(0, 4);
      if (kind == 0) begin
        // small alphabet, finals scattered anywhere
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          queue_byte(8'($urandom_range(0, 2)),
                     (i == len - 1) || ($urandom_range(0, 3) == 0));
      end else begin
        chunks = $urandom_range(1, 5);
        for (int c = 0; c < chunks; c++) begin
          last = (c == chunks - 1);
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
          rb = 8'($urandom);
          if ($urandom_range(0, 1) != 0) queue_run(rb, len, last);
          else queue_literal(len, last);
        end
      end
    end

    // synchronous reset, then release
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // wait for every transaction to go in and every word to come out
    while (raw_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (encoded_words_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (encoded_words_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, encoded_words_q.size());
    end
    $display("covered %0d byte transactions in %0d streams, %0d encoded words checked",
             n_in, n_streams, n_words);
    $display("runs and literals up to full segments, lone final bytes, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("rle_run_literal_encoder_unit_tb passed");
    end else begin
      $display("rle_run_literal_encoder_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/rle_pkg.sv
src/rle_run_literal_encoder_unit.sv
tb/rle_run_literal_encoder_unit_tb.sv
